/* design/ncr_pkg.sv */
// Shared types and constants of the IPv4 static NAT checksum rewriter.
package ncr_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int RSP_TDATA_W = 136;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 32;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_MATCH_ADDR   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_REPLACE_ADDR = 1'b1;

   localparam logic [31:0] MATCH_ADDR_RESET   = 32'hDCB5_2537;
   localparam logic [31:0] REPLACE_ADDR_RESET = 32'h40E9_BD68;

   localparam logic [7:0] PROTO_TCP = 8'd6;

   // Per-packet summary handed from the byte front end to the checksum back end
   typedef struct packed {
      logic [15:0] hdr_sum;     // folded header sum without check and address words
      logic [15:0] seg_sum;     // folded segment sum without the TCP check word
      logic [15:0] ip_check;
      logic [15:0] tcp_check;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] tcp_len;
      logic [7:0]  protocol;
      logic        truncated;
   } snap_type;

endpackage

/* design/ncr_front.sv */
// Byte front end: parses the IPv4 header and keeps the running checksums.
module ncr_front #(
   parameter int MAX_BYTES = 65535
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [7:0]        in_byte,
   input  logic              in_last,
   input  logic              q_full,
   output logic              q_push,
   output ncr_pkg::snap_type q_data
);
   import ncr_pkg::*;

   localparam int IDX_W = $clog2(MAX_BYTES + 1);

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [3:0]       ihl_ff, ihl_in;
   logic [15:0]      tl_ff, tl_in;
   logic [7:0]       proto_ff, proto_in;
   logic [15:0]      oip_ff, oip_in;
   logic [15:0]      otcp_ff, otcp_in;
   logic [31:0]      src_ff, src_in;
   logic [31:0]      dst_ff, dst_in;
   logic [15:0]      hsum_ff, hsum_in;
   logic [15:0]      ssum_ff, ssum_in;

   logic        accept, take, in_hdr;
   logic [15:0] idx16, weighted, hlen16;
   logic [3:0]  ihl_eff;
   logic [5:0]  hlen;

   function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
   endfunction

   assign in_ready = !q_full;
   assign accept   = in_valid && in_ready;
   assign take     = idx_ff < IDX_W'(MAX_BYTES);
   assign idx16    = 16'(idx_ff);
   assign weighted = idx_ff[0] ? {8'h00, in_byte} : {in_byte, 8'h00};
   assign ihl_eff  = (ihl_in < 4'd5) ? 4'd5 : ihl_in;
   assign hlen     = {ihl_eff, 2'b00};
   assign hlen16   = {10'd0, hlen};
   assign in_hdr   = idx16 < hlen16;

   always_comb begin
      ihl_in   = ihl_ff;
      tl_in    = tl_ff;
      proto_in = proto_ff;
      oip_in   = oip_ff;
      otcp_in  = otcp_ff;
      src_in   = src_ff;
      dst_in   = dst_ff;
      hsum_in  = hsum_ff;
      ssum_in  = ssum_ff;
      idx_in   = idx_ff;
      if (take) begin
         idx_in = idx_ff + IDX_W'(1);
         case (idx16)
            16'd0:  ihl_in         = in_byte[3:0];
            16'd2:  tl_in[15:8]    = in_byte;
            16'd3:  tl_in[7:0]     = in_byte;
            16'd9:  proto_in       = in_byte;
            16'd10: oip_in[15:8]   = in_byte;
            16'd11: oip_in[7:0]    = in_byte;
            16'd12: src_in[31:24]  = in_byte;
            16'd13: src_in[23:16]  = in_byte;
            16'd14: src_in[15:8]   = in_byte;
            16'd15: src_in[7:0]    = in_byte;
            16'd16: dst_in[31:24]  = in_byte;
            16'd17: dst_in[23:16]  = in_byte;
            16'd18: dst_in[15:8]   = in_byte;
            16'd19: dst_in[7:0]    = in_byte;
            default: ;
         endcase
         if (in_hdr) begin
            // check and address bytes are captured, not summed
            if (idx16 < 16'd10 || idx16 > 16'd19)
               hsum_in = oc_add(hsum_ff, weighted);
         end else if (idx16 < tl_in) begin
            if (idx16 == hlen16 + 16'd16)
               otcp_in[15:8] = in_byte;
            else if (idx16 == hlen16 + 16'd17)
               otcp_in[7:0] = in_byte;
            else
               ssum_in = oc_add(ssum_ff, weighted);
         end
      end
   end

   always_comb begin
      q_push           = accept && in_last;
      q_data.hdr_sum   = hsum_in;
      q_data.seg_sum   = ssum_in;
      q_data.ip_check  = oip_in;
      q_data.tcp_check = otcp_in;
      q_data.src_addr  = src_in;
      q_data.dst_addr  = dst_in;
      q_data.tcp_len   = tl_in - hlen16;
      q_data.protocol  = proto_in;
      q_data.truncated = 16'(idx_in) < tl_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && in_last)) begin
         idx_ff   <= '0;
         ihl_ff   <= '0;
         tl_ff    <= '0;
         proto_ff <= '0;
         oip_ff   <= '0;
         otcp_ff  <= '0;
         src_ff   <= '0;
         dst_ff   <= '0;
         hsum_ff  <= '0;
         ssum_ff  <= '0;
      end else if (accept) begin
         idx_ff   <= idx_in;
         ihl_ff   <= ihl_in;
         tl_ff    <= tl_in;
         proto_ff <= proto_in;
         oip_ff   <= oip_in;
         otcp_ff  <= otcp_in;
         src_ff   <= src_in;
         dst_ff   <= dst_in;
         hsum_ff  <= hsum_in;
         ssum_ff  <= ssum_in;
      end
   end

endmodule

/* design/ncr_queue.sv */
// Short queue of packet summaries between the front end and the back end.
module ncr_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ncr_pkg::snap_type push_data,
   output logic              full,
   input  logic              pop,
   output ncr_pkg::snap_type pop_data,
   output logic              empty
);
   import ncr_pkg::*;

   snap_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]  count_ff, count_in;
   logic                    do_push, do_pop;

   assign full     = count_ff == QUEUE_CNT_W'(QUEUE_DEPTH);
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop)
         count_in = count_ff + QUEUE_CNT_W'(1);
      else if (do_pop && !do_push)
         count_in = count_ff - QUEUE_CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push)
         entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

/* design/ncr_back.sv */
// Back end: address translation and checksum pipeline with output register.
module ncr_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_empty,
   input  ncr_pkg::snap_type               q_data,
   output logic                            q_pop,
   input  logic                            csr_we,
   input  logic [ncr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ncr_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic [ncr_pkg::RSP_TDATA_W-1:0] out_data
);
   import ncr_pkg::*;

   typedef struct packed {
      logic        drw;
      logic        srw;
      logic        tcp;
      logic        trunc;
      logic [31:0] nsrc;
      logic [31:0] ndst;
   } flags_type;

   typedef struct packed {
      flags_type   f;
      logic [16:0] a_src;
      logic [16:0] a_dst;
      logic [16:0] n_src;
      logic [16:0] n_dst;
      logic [16:0] pseudo;
      logic [16:0] hb;
      logic [16:0] tb;
      logic [15:0] hsum;
      logic [15:0] ssum;
   } st1_type;

   typedef struct packed {
      flags_type   f;
      logic [16:0] hb;
      logic [15:0] hsum;
      logic [17:0] old_addr;
      logic [17:0] new_addr;
      logic [17:0] tb2;
      logic [17:0] ta2;
   } st2_type;

   typedef struct packed {
      flags_type   f;
      logic [18:0] ipb;
      logic [18:0] ipa;
      logic [18:0] tcpb;
      logic [18:0] tcpa;
   } st3_type;

   logic [31:0] match_ff, replace_ff;
   st1_type     s1_ff, s1_in;
   st2_type     s2_ff, s2_in;
   st3_type     s3_ff;
   logic        v1_ff, v2_ff, v3_ff, out_valid_ff;
   logic [RSP_TDATA_W-1:0] out_data_ff, out_data_in;
   logic        advance;
   logic [15:0] ipb_f, ipa_f, tcpb_f, tcpa_f;

   function automatic logic [15:0] fold_cpl(input logic [18:0] s);
      logic [16:0] f1;
      logic [15:0] f2;
      f1 = {1'b0, s[15:0]} + {14'd0, s[18:16]};
      f2 = f1[15:0] + {15'd0, f1[16]};
      return ~f2;
   endfunction

   // whole pipeline holds while the output register is stalled
   assign advance   = !out_valid_ff || out_ready;
   assign q_pop     = advance && !q_empty;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff   <= MATCH_ADDR_RESET;
         replace_ff <= REPLACE_ADDR_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_MATCH_ADDR:   match_ff   <= csr_wdata;
            REG_REPLACE_ADDR: replace_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      s1_in.f.drw   = q_data.dst_addr == match_ff;
      s1_in.f.srw   = q_data.src_addr == replace_ff;
      s1_in.f.tcp   = q_data.protocol == PROTO_TCP;
      s1_in.f.trunc = q_data.truncated;
      s1_in.f.nsrc  = s1_in.f.srw ? match_ff : q_data.src_addr;
      s1_in.f.ndst  = s1_in.f.drw ? replace_ff : q_data.dst_addr;
      s1_in.a_src   = 17'(q_data.src_addr[31:16]) + 17'(q_data.src_addr[15:0]);
      s1_in.a_dst   = 17'(q_data.dst_addr[31:16]) + 17'(q_data.dst_addr[15:0]);
      s1_in.n_src   = 17'(s1_in.f.nsrc[31:16]) + 17'(s1_in.f.nsrc[15:0]);
      s1_in.n_dst   = 17'(s1_in.f.ndst[31:16]) + 17'(s1_in.f.ndst[15:0]);
      s1_in.pseudo  = 17'(q_data.protocol) + 17'(q_data.tcp_len);
      s1_in.hb      = 17'(q_data.hdr_sum) + 17'(q_data.ip_check);
      s1_in.tb      = 17'(q_data.seg_sum) + 17'(q_data.tcp_check);
      s1_in.hsum    = q_data.hdr_sum;
      s1_in.ssum    = q_data.seg_sum;
   end

   always_comb begin
      s2_in.f        = s1_ff.f;
      s2_in.hb       = s1_ff.hb;
      s2_in.hsum     = s1_ff.hsum;
      s2_in.old_addr = 18'(s1_ff.a_src) + 18'(s1_ff.a_dst);
      s2_in.new_addr = 18'(s1_ff.n_src) + 18'(s1_ff.n_dst);
      s2_in.tb2      = 18'(s1_ff.tb) + 18'(s1_ff.pseudo);
      s2_in.ta2      = 18'(s1_ff.ssum) + 18'(s1_ff.pseudo);
   end

   always_comb begin
      ipb_f  = fold_cpl(s3_ff.ipb);
      ipa_f  = fold_cpl(s3_ff.ipa);
      tcpb_f = s3_ff.f.tcp ? fold_cpl(s3_ff.tcpb) : 16'd0;
      tcpa_f = s3_ff.f.tcp ? fold_cpl(s3_ff.tcpa) : 16'd0;
      out_data_in = {4'h0, s3_ff.f.trunc, s3_ff.f.tcp, s3_ff.f.srw, s3_ff.f.drw,
                     tcpa_f, ipa_f, tcpb_f, ipb_f, s3_ff.f.ndst, s3_ff.f.nsrc};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         v1_ff        <= !q_empty;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         out_valid_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff        <= s1_in;
         s2_ff        <= s2_in;
         s3_ff.f      <= s2_ff.f;
         s3_ff.ipb    <= 19'(s2_ff.hb) + 19'(s2_ff.old_addr);
         s3_ff.ipa    <= 19'(s2_ff.hsum) + 19'(s2_ff.new_addr);
         s3_ff.tcpb   <= 19'(s2_ff.tb2) + 19'(s2_ff.old_addr);
         s3_ff.tcpa   <= 19'(s2_ff.ta2) + 19'(s2_ff.new_addr);
         out_data_ff  <= out_data_in;
      end
   end

endmodule

/* design/ipv4_static_nat_checksum_rewriter_top.sv */
// Top level of the IPv4 static NAT rewriter with header and TCP checksums.
// Throughput: one packet byte per cycle while the summary queue is not full;
// results may leave one per cycle while rsp_tready is high. The summary of a
// packet passes the queue write, then three checksum stages and the output register.
// req_tready drops only while the four-entry summary queue is full.
// Reset is synchronous: it clears packet state, queue and pipeline and loads
// the default match and replacement addresses.
module ipv4_static_nat_checksum_rewriter_top #(
   parameter int MAX_PACKET_BYTES = 65535
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,  // [7:0] data_byte
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [31:0] new_source_addr, [63:32] new_dest_addr, [79:64] ip_check_before,
   // [95:80] tcp_check_before, [111:96] ip_check_after,
   // [127:112] tcp_check_after, [128] dest_rewritten, [129] source_rewritten,
   // [130] is_tcp, [131] truncated, [135:132] zero
   output logic [ncr_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                            csr_we,
   input  logic [ncr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ncr_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import ncr_pkg::*;

   snap_type push_data, pop_data;
   logic     push, pop, q_full, q_empty;

   ncr_front #(
      .MAX_BYTES (MAX_PACKET_BYTES)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_byte  (req_tdata),
      .in_last  (req_tlast),
      .q_full   (q_full),
      .q_push   (push),
      .q_data   (push_data)
   );

   ncr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (q_empty)
   );

   ncr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (pop_data),
      .q_pop     (pop),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata)
   );

endmodule

/* design/ncr_checker.sv */
// Port-level checker for the NAT rewriter, bound to the top level.
module ncr_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [ncr_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import ncr_pkg::*;

   // a stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped during stall");

   // a stalled result keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("rsp_tdata changed during stall");

   // no result and an open request side right after reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid && req_tready)
      else $error("result offered or request blocked right after reset");

   // non-TCP packets carry zero TCP checks
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[130] |-> rsp_tdata[127:112] == 16'd0
                                     && rsp_tdata[95:80] == 16'd0)
      else $error("TCP check set on non-TCP packet");

   // a result must first pass the queue and the pipeline, so none appears just as reset falls
   assert property (@(posedge clock)
      $fell(reset) |-> !rsp_tvalid [*4])
      else $error("result appeared too early");

endmodule

bind ipv4_static_nat_checksum_rewriter_top ncr_checker u_checker (.*);
